/* hdl/duplex_frame_exchange_queue_assert.svh */
// Assertion macros shared by the frame exchange queue RTL.
`ifndef DUPLEX_FRAME_EXCHANGE_QUEUE_ASSERT_SVH
`define DUPLEX_FRAME_EXCHANGE_QUEUE_ASSERT_SVH

// same-cycle implication
`define DFEQ_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame exchange queue assertion failed");

// next-cycle implication
`define DFEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame exchange queue assertion failed");

`endif

/* hdl/dfeq_pkg.sv */
// Shared constants, types and tables of the frame exchange queue.
package dfeq_pkg;

   localparam int FRAME_WORDS_DEF  = 64;
   localparam int QUEUE_FRAMES_DEF = 64;

   localparam int WORD_W = 16;
   localparam int CNT_W  = 32;
   localparam int KIND_W = 6;
   localparam int OFS_W  = 6;
   localparam int LEN_W  = 8;

   localparam logic [WORD_W-1:0] SYNC_WORD    = 16'h5533;
   localparam logic [WORD_W-1:0] TRAILER_WORD = 16'hAACC;

   localparam logic REQ_EXCHANGE = 1'b0;
   localparam logic REQ_QUEUE    = 1'b1;

   localparam logic [KIND_W-1:0] KIND_NONE   = 6'd0;
   localparam logic [KIND_W-1:0] KIND_ST32   = 6'd1;
   localparam logic [KIND_W-1:0] KIND_ST42   = 6'd2;
   localparam logic [KIND_W-1:0] KIND_ST52   = 6'd3;
   localparam logic [KIND_W-1:0] KIND_ST38   = 6'd4;
   localparam logic [KIND_W-1:0] KIND_ST4    = 6'd5;
   localparam logic [KIND_W-1:0] KIND_ST20   = 6'd6;

   typedef struct packed {
      logic              fire;
      logic              sof;
      logic              hdr;
      logic              eof;
      logic [WORD_W-1:0] word;
   } rxd_ctl_type;

   typedef struct packed {
      logic              done;
      logic [1:0]        check;
      logic [KIND_W-1:0] kind;
      logic [1:0]        flags;
      logic [LEN_W-1:0]  len;
      logic [OFS_W-1:0]  offset;
   } rxd_res_type;

   function automatic logic [OFS_W-1:0] status_size(input logic [KIND_W-1:0] kind);
      logic [OFS_W-1:0] st;
      unique case (kind)
         KIND_NONE: st = 6'd0;
         KIND_ST32: st = 6'd32;
         KIND_ST42: st = 6'd42;
         KIND_ST52: st = 6'd52;
         KIND_ST38: st = 6'd38;
         KIND_ST4:  st = 6'd4;
         KIND_ST20: st = 6'd20;
         default:   st = 6'd0;
      endcase
      return st;
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
   endfunction

endpackage

/* hdl/dfeq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dfeq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/dfeq_rx_decode.sv */
// Receive-side capture of sync and header words, frame decode and error counters.
module dfeq_rx_decode #(
   parameter int FRAME_WORDS = dfeq_pkg::FRAME_WORDS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dfeq_pkg::rxd_ctl_type      ctl,
   output dfeq_pkg::rxd_res_type      res,
   output logic [dfeq_pkg::CNT_W-1:0] good_total_in,
   output logic [dfeq_pkg::CNT_W-1:0] sync_errors_in,
   output logic [dfeq_pkg::CNT_W-1:0] trailer_errors_in
);
   import dfeq_pkg::*;

   localparam int SUM_W = 10;

   logic [WORD_W-1:0] rx_sync_ff;
   logic [WORD_W-1:0] rx_header_ff;
   logic [CNT_W-1:0]  good_total_ff;
   logic [CNT_W-1:0]  sync_errors_ff;
   logic [CNT_W-1:0]  trailer_errors_ff;

   logic [KIND_W-1:0] kind;
   logic [LEN_W-1:0]  len;
   logic [OFS_W-1:0]  st;
   logic [SUM_W-1:0]  need;
   logic              sync_ok;
   logic              trl_ok;
   logic              fits;
   logic              end_beat;

   always_comb begin
      kind     = rx_header_ff[KIND_W-1:0];
      len      = rx_header_ff[15:8];
      st       = status_size(kind);
      need     = SUM_W'(2) + SUM_W'(st) + SUM_W'(len);
      sync_ok  = (rx_sync_ff == SYNC_WORD);
      trl_ok   = (ctl.word == TRAILER_WORD);
      fits     = (len != '0) && (need <= SUM_W'(FRAME_WORDS - 1));
      end_beat = ctl.fire && ctl.eof;

      res = '0;
      if (end_beat) begin
         res.done   = 1'b1;
         res.check  = {trl_ok, sync_ok};
         res.kind   = kind;
         res.flags  = rx_header_ff[7:6];
         res.len    = len;
         res.offset = fits ? st + OFS_W'(2) : '0;
      end

      good_total_in     = good_total_ff;
      sync_errors_in    = sync_errors_ff;
      trailer_errors_in = trailer_errors_ff;
      if (end_beat) begin
         good_total_in = sat_inc(good_total_ff);
         if (!sync_ok) begin
            sync_errors_in = sat_inc(sync_errors_ff);
         end else if (!trl_ok) begin
            trailer_errors_in = sat_inc(trailer_errors_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_sync_ff        <= '0;
         rx_header_ff      <= '0;
         good_total_ff     <= '0;
         sync_errors_ff    <= '0;
         trailer_errors_ff <= '0;
      end else begin
         if (ctl.fire && ctl.sof) begin
            rx_sync_ff <= ctl.word;
         end
         if (ctl.fire && ctl.hdr) begin
            rx_header_ff <= ctl.word;
         end
         good_total_ff     <= good_total_in;
         sync_errors_ff    <= sync_errors_in;
         trailer_errors_ff <= trailer_errors_in;
      end
   end

endmodule

/* hdl/duplex_frame_exchange_queue.sv */
// Top level: frame queue control, transmit sequencing and result register.
// Accepting a beat in the idle state issues the frame-store and frame-length reads; the
// execute state then turns the registered read data into the result and updates the
// queue state once the output register is free. No new beat is accepted until the last
// one leaves the execute state. A finished result waits in the output register while
// the next beat is accepted. Queued frames live in (QUEUE_FRAMES+1)*FRAME_WORDS words
// of frame store; the extra slot keeps the frame on the wire intact while new frames
// fill, and a per-slot length store zero-fills the short tail on the fly, so neither
// memory needs a clearing pass after reset.
`include "duplex_frame_exchange_queue_assert.svh"
module duplex_frame_exchange_queue #(
   parameter int FRAME_WORDS  = dfeq_pkg::FRAME_WORDS_DEF,
   parameter int QUEUE_FRAMES = dfeq_pkg::QUEUE_FRAMES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [dfeq_pkg::WORD_W-1:0]         req_rx_word,
   input  logic [dfeq_pkg::WORD_W-1:0]         req_queue_word,
   input  logic                                req_queue_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_accepted,
   output logic [dfeq_pkg::WORD_W-1:0]         rsp_tx_word,
   output logic                                rsp_frame_done,
   output logic [1:0]                          rsp_frame_check,
   output logic [dfeq_pkg::KIND_W-1:0]         rsp_frame_kind,
   output logic [1:0]                          rsp_frame_flags,
   output logic [dfeq_pkg::LEN_W-1:0]          rsp_reply_len,
   output logic [dfeq_pkg::OFS_W-1:0]          rsp_reply_offset,
   output logic [dfeq_pkg::CNT_W-1:0]          rsp_exchange_count,
   output logic [dfeq_pkg::CNT_W-1:0]          rsp_bad_count,
   output logic [dfeq_pkg::CNT_W-1:0]          rsp_bad_trailer_count,
   output logic [$clog2(QUEUE_FRAMES+1)-1:0]   rsp_queue_level
);
   import dfeq_pkg::*;

   localparam int PW    = $clog2(FRAME_WORDS);
   localparam int LW    = $clog2(FRAME_WORDS + 1);
   localparam int NSLOT = QUEUE_FRAMES + 1;
   localparam int SW    = $clog2(NSLOT);
   localparam int QW    = $clog2(QUEUE_FRAMES + 1);
   localparam int AW    = $clog2(NSLOT * FRAME_WORDS);

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_EXEC = 1'b1;

   localparam logic [PW-1:0] POS_LAST = PW'(FRAME_WORDS - 1);

   logic [0:0]        state_ff, state_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [SW-1:0]     head_ff, head_in;
   logic [QW-1:0]     count_ff, count_in;
   logic [LW-1:0]     fill_pos_ff, fill_pos_in;
   logic              fill_reject_ff, fill_reject_in;
   logic              tx_live_ff, tx_live_in;
   logic [SW-1:0]     tx_slot_ff, tx_slot_in;
   logic [LW-1:0]     tx_len_ff, tx_len_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              type_ff;
   logic [WORD_W-1:0] rx_ff;
   logic [WORD_W-1:0] qword_ff;
   logic              qlast_ff;

   logic              rsp_accepted_ff;
   logic [WORD_W-1:0] rsp_tx_word_ff;
   rxd_res_type       rsp_res_ff;
   logic [CNT_W-1:0]  rsp_good_ff;
   logic [CNT_W-1:0]  rsp_sync_ff;
   logic [CNT_W-1:0]  rsp_trl_ff;
   logic [QW-1:0]     rsp_level_ff;

   logic              accept;
   logic              out_free;
   logic              fire;
   logic              is_xchg;
   logic              sof;
   logic              eof;
   logic              live_now;
   logic [LW-1:0]     len_now;
   logic [WORD_W-1:0] tx_word;
   logic              q_reject;
   logic [SW:0]       slot_sum;
   logic [SW-1:0]     fill_slot;
   logic [SW-1:0]     head_next;
   logic [SW-1:0]     rd_slot;
   logic [AW-1:0]     store_rd_addr;
   logic [AW-1:0]     store_wr_addr;
   logic              store_wr_en;
   logic              len_wr_en;
   logic [WORD_W-1:0] store_rd_data;
   logic [LW-1:0]     len_rd_data;
   logic [LW-1:0]     fill_pos_inc;

   rxd_ctl_type       rxd_ctl;
   rxd_res_type       rxd_res;
   logic [CNT_W-1:0]  good_total_in;
   logic [CNT_W-1:0]  sync_errors_in;
   logic [CNT_W-1:0]  trailer_errors_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = (state_ff == ST_EXEC) && out_free;

   always_comb begin
      slot_sum  = (SW+1)'(head_ff) + (SW+1)'(count_ff);
      fill_slot = (slot_sum >= (SW+1)'(NSLOT)) ? SW'(slot_sum - (SW+1)'(NSLOT))
                                               : SW'(slot_sum);
      head_next = (head_ff == SW'(NSLOT - 1)) ? '0 : head_ff + 1'b1;
      rd_slot   = (pos_ff == '0) ? head_ff : tx_slot_ff;

      store_rd_addr = AW'(rd_slot) * AW'(FRAME_WORDS) + AW'(pos_ff);
      store_wr_addr = AW'(fill_slot) * AW'(FRAME_WORDS) + AW'(fill_pos_ff);
      fill_pos_inc  = fill_pos_ff + 1'b1;

      is_xchg  = (type_ff == REQ_EXCHANGE);
      sof      = (pos_ff == '0);
      eof      = (pos_ff == POS_LAST);
      live_now = sof ? (count_ff != '0) : tx_live_ff;
      len_now  = sof ? len_rd_data : tx_len_ff;
      tx_word  = (live_now && (LW'(pos_ff) < len_now)) ? store_rd_data : '0;

      q_reject = fill_reject_ff || (count_ff >= QW'(QUEUE_FRAMES))
                 || (fill_pos_ff >= LW'(FRAME_WORDS));

      store_wr_en = fire && !is_xchg && !q_reject;
      len_wr_en   = store_wr_en && qlast_ff;
   end

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      fill_pos_in    = fill_pos_ff;
      fill_reject_in = fill_reject_ff;
      tx_live_in     = tx_live_ff;
      tx_slot_in     = tx_slot_ff;
      tx_len_in      = tx_len_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (fire && is_xchg) begin
         pos_in = eof ? '0 : pos_ff + 1'b1;
         if (sof) begin
            tx_live_in = live_now;
            tx_slot_in = head_ff;
            tx_len_in  = len_rd_data;
            if (live_now) begin
               head_in  = head_next;
               count_in = count_ff - 1'b1;
            end
         end
      end

      if (fire && !is_xchg) begin
         if (!q_reject) begin
            fill_pos_in = fill_pos_inc;
         end
         if (qlast_ff) begin
            if (!q_reject) begin
               count_in = count_ff + 1'b1;
            end
            fill_pos_in    = '0;
            fill_reject_in = 1'b0;
         end else begin
            fill_reject_in = q_reject;
         end
      end

      rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);
   end

   assign rxd_ctl.fire = fire && is_xchg;
   assign rxd_ctl.sof  = sof;
   assign rxd_ctl.hdr  = (pos_ff == PW'(1));
   assign rxd_ctl.eof  = eof;
   assign rxd_ctl.word = rx_ff;

   dfeq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NSLOT * FRAME_WORDS)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (qword_ff),
      .rd_en   (accept),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   dfeq_ram #(
      .WIDTH (LW),
      .DEPTH (NSLOT)
   ) u_frame_len (
      .clock   (clock),
      .wr_en   (len_wr_en),
      .wr_addr (fill_slot),
      .wr_data (fill_pos_inc),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (len_rd_data)
   );

   dfeq_rx_decode #(
      .FRAME_WORDS (FRAME_WORDS)
   ) u_rx_decode (
      .clock             (clock),
      .reset             (reset),
      .ctl               (rxd_ctl),
      .res               (rxd_res),
      .good_total_in     (good_total_in),
      .sync_errors_in    (sync_errors_in),
      .trailer_errors_in (trailer_errors_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pos_ff         <= '0;
         head_ff        <= '0;
         count_ff       <= '0;
         fill_pos_ff    <= '0;
         fill_reject_ff <= 1'b0;
         tx_live_ff     <= 1'b0;
         tx_slot_ff     <= '0;
         tx_len_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pos_ff         <= pos_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
         fill_pos_ff    <= fill_pos_in;
         fill_reject_ff <= fill_reject_in;
         tx_live_ff     <= tx_live_in;
         tx_slot_ff     <= tx_slot_in;
         tx_len_ff      <= tx_len_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff  <= req_type;
         rx_ff    <= req_rx_word;
         qword_ff <= req_queue_word;
         qlast_ff <= req_queue_last;
      end
      if (fire) begin
         rsp_accepted_ff <= !is_xchg && !q_reject;
         rsp_tx_word_ff  <= is_xchg ? tx_word : '0;
         rsp_res_ff      <= rxd_res;
         rsp_good_ff     <= good_total_in;
         rsp_sync_ff     <= sync_errors_in;
         rsp_trl_ff      <= trailer_errors_in;
         rsp_level_ff    <= count_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_accepted          = rsp_accepted_ff;
   assign rsp_tx_word           = rsp_tx_word_ff;
   assign rsp_frame_done        = rsp_res_ff.done;
   assign rsp_frame_check       = rsp_res_ff.check;
   assign rsp_frame_kind        = rsp_res_ff.kind;
   assign rsp_frame_flags       = rsp_res_ff.flags;
   assign rsp_reply_len         = rsp_res_ff.len;
   assign rsp_reply_offset      = rsp_res_ff.offset;
   assign rsp_exchange_count    = rsp_good_ff;
   assign rsp_bad_count         = rsp_sync_ff;
   assign rsp_bad_trailer_count = rsp_trl_ff;
   assign rsp_queue_level       = rsp_level_ff;

   `DFEQ_ASSERT(a_fill_bound, clock, reset, 1'b1, fill_pos_ff <= LW'(FRAME_WORDS))
   `DFEQ_ASSERT(a_count_bound, clock, reset, 1'b1, count_ff <= QW'(QUEUE_FRAMES))
   `DFEQ_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == ST_EXEC)
   `DFEQ_ASSERT_NEXT(a_hold_exec, clock, reset, (state_ff == ST_EXEC) && !out_free,
      (state_ff == ST_EXEC) && rsp_valid_ff)
   `DFEQ_ASSERT_NEXT(a_dequeue, clock, reset, fire && is_xchg && sof && (count_ff != '0),
      count_ff == ($past(count_ff) - QW'(1)))
   `DFEQ_ASSERT(a_tx_slot_pinned, clock, reset,
      tx_live_ff && (count_ff < QW'(QUEUE_FRAMES)), fill_slot != tx_slot_ff)

endmodule
